### hw/rtl/ssmd_pkg.sv
// Shared types, constants and glyph decode for the seven-segment mux driver.
`default_nettype none

package ssmd_pkg;

   // Digits on the display and derived widths
   localparam int NUM_DIGITS = 3;
   localparam int PHASE_W    = $clog2(NUM_DIGITS + 1);
   localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int DIGIT_W    = 3;    // visible digit enable pins
   localparam int SEG_W      = 8;    // hgfedcba
   localparam int CODE_W     = 5;
   localparam int VALUE_W    = 10;
   localparam int DEC_DIGITS = 3;    // decimal digits of the largest value

   localparam logic [VALUE_W-1:0] MAX_VALUE  = VALUE_W'(999);
   localparam logic [CODE_W-1:0]  BLANK_CODE = CODE_W'(25);

   // Request kinds carried on tuser
   typedef enum logic {
      CMD_SET  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef logic [CODE_W-1:0] code_type;

   // Digit code update from the splitter to the scan logic
   typedef struct packed {
      logic                            load;
      logic [NUM_DIGITS-1:0][CODE_W-1:0] codes;
   } codes_upd_type;

   // Pin levels as one result
   typedef struct packed {
      logic [SEG_W-1:0]   segment;
      logic [DIGIT_W-1:0] digit;
   } pins_type;

   // Glyph table, segments active high, bit order hgfedcba
   function automatic logic [SEG_W-1:0] glyph(input code_type code);
      logic [SEG_W-1:0] pat;
      case (code)
         5'd0:    pat = 8'h3F;
         5'd1:    pat = 8'h06;
         5'd2:    pat = 8'h5B;
         5'd3:    pat = 8'h4F;
         5'd4:    pat = 8'h66;
         5'd5:    pat = 8'h6D;
         5'd6:    pat = 8'h7D;
         5'd7:    pat = 8'h07;
         5'd8:    pat = 8'h7F;
         5'd9:    pat = 8'h6F;
         5'd10:   pat = 8'h5F;
         5'd11:   pat = 8'h7C;
         5'd12:   pat = 8'h58;
         5'd13:   pat = 8'h5E;
         5'd14:   pat = 8'h7B;
         5'd15:   pat = 8'h71;
         5'd16:   pat = 8'h77;
         5'd17:   pat = 8'h39;
         5'd18:   pat = 8'h79;
         5'd19:   pat = 8'h76;
         5'd20:   pat = 8'h1E;
         5'd21:   pat = 8'h38;
         5'd22:   pat = 8'h73;
         5'd23:   pat = 8'h3E;
         5'd24:   pat = 8'h80;
         default: pat = 8'h00;   // blank, and codes past the table
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ssmd_digit_split.sv
// Splits a value of 0 to 999 into blanked decimal digit codes.
`default_nettype none

module ssmd_digit_split (
   input  wire logic                          load,
   input  wire logic [ssmd_pkg::VALUE_W-1:0]  value,
   output ssmd_pkg::codes_upd_type            upd
);

   localparam int DEC_DIGITS_L = ssmd_pkg::DEC_DIGITS;

   logic [17:0] tens_prod;
   logic [15:0] hund_prod;
   logic [6:0]  q10;        // value / 10
   logic [3:0]  hund;
   logic [9:0]  units_full;
   logic [6:0]  tens_full;
   logic [DEC_DIGITS_L-1:0][3:0] dec;
   logic [DEC_DIGITS_L-1:0]      blank;

   // reciprocal multiplies, exact for values below 1000
   assign tens_prod  = 18'(value) * 18'd205;
   assign q10        = tens_prod[17:11];
   assign hund_prod  = 16'(value) * 16'd41;
   assign hund       = hund_prod[15:12];
   assign units_full = value - 10'(q10) * 10'd10;
   assign tens_full  = q10 - 7'(hund) * 7'd10;

   assign dec[0]   = units_full[3:0];
   assign dec[1]   = tens_full[3:0];
   assign dec[2]   = hund;
   assign blank[0] = 1'b0;
   assign blank[1] = (value < ssmd_pkg::VALUE_W'(10));
   assign blank[2] = (value < ssmd_pkg::VALUE_W'(100));

   always_comb begin
      upd.load = load && (value <= ssmd_pkg::MAX_VALUE);
      for (int k = 0; k < ssmd_pkg::NUM_DIGITS; k++) begin
         if (k < DEC_DIGITS_L && !blank[k % DEC_DIGITS_L]) begin
            upd.codes[k] = ssmd_pkg::CODE_W'(dec[k % DEC_DIGITS_L]);
         end else begin
            upd.codes[k] = ssmd_pkg::BLANK_CODE;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ssmd_scan.sv
// Digit code store, polarity register, scan phase and pin level registers.
`default_nettype none

module ssmd_scan (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_wr_data,
   input  wire logic                tick,
   input  wire ssmd_pkg::codes_upd_type  upd,
   output ssmd_pkg::pins_type       pins_next
);

   logic                                         polarity_ff;
   logic [ssmd_pkg::PHASE_W-1:0]                 phase_ff, phase_in;
   logic [ssmd_pkg::NUM_DIGITS-1:0][ssmd_pkg::CODE_W-1:0] codes_ff, codes_in;
   ssmd_pkg::pins_type                           pins_ff, pins_in;

   logic [ssmd_pkg::DIGIT_W-1:0] off_mask;
   logic [ssmd_pkg::SEG_W-1:0]   pattern;
   logic                         lit_phase;

   assign off_mask  = polarity_ff ? '0 : '1;
   assign lit_phase = (phase_ff < ssmd_pkg::PHASE_W'(ssmd_pkg::NUM_DIGITS));
   assign pattern   = ssmd_pkg::glyph(codes_ff[phase_ff[ssmd_pkg::IDX_W-1:0]]);

   always_comb begin
      codes_in = upd.load ? upd.codes : codes_ff;
      phase_in = phase_ff;
      pins_in  = pins_ff;
      if (tick) begin
         pins_in.digit = off_mask;
         if (lit_phase) begin
            pins_in.digit   = off_mask ^ (ssmd_pkg::DIGIT_W'(1) << phase_ff);
            pins_in.segment = polarity_ff ? ~pattern : pattern;
            phase_in        = phase_ff + 1'b1;
         end else begin
            // dark phase: segments hold, scan wraps
            phase_in = '0;
         end
      end
   end

   assign pins_next = pins_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff     <= 1'b0;
         phase_ff        <= '0;
         codes_ff        <= {ssmd_pkg::NUM_DIGITS{ssmd_pkg::BLANK_CODE}};
         pins_ff.digit   <= '1;
         pins_ff.segment <= '0;
      end else begin
         if (csr_wr_en) begin
            polarity_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         codes_ff <= codes_in;
         pins_ff  <= pins_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ssmd_out_buf.sv
// Two-entry result buffer that decouples the request side from rsp_tready.
`default_nettype none

module ssmd_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ssmd_pkg::pins_type  push_data,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ssmd_pkg::pins_type       out_data
);

   ssmd_pkg::pins_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, wr_ptr_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/seven_segment_mux_driver_core.sv
// Top level of the three-digit multiplexed seven-segment display driver.
//
// Request channel (req_*): each transfer is one command. tuser selects the
// kind: set value (tdata carries the number, 0 to 999 shown, larger values
// ignored) or refresh tick (tdata unused). Every request gives exactly one
// response transfer (rsp_*) with the digit enable and segment pin levels as
// they stand after the command; a set value repeats the current levels.
// The response is written into the result buffer on the request transfer.
// Throughput: one request per cycle while the result buffer is not full, set by
// the single decode stage between the state registers and the two-entry result buffer.
// csr_wr_en/csr_wr_data write the polarity bit (1: inverted pin levels);
// it takes effect on the pins at the next refresh tick.
// Reset (synchronous, active high): scan phase 0, all digits blank, digit
// pins at the off level (3'b111), segments 0, polarity common cathode,
// response buffer empty.
// Receiver stall: results pile up in the two-entry buffer; req_tready drops
// only when both entries are held, so no result is lost or repeated.
`default_nettype none

module seven_segment_mux_driver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [9:0] value, [15:10] zero
   input  wire logic        req_tuser,   // [0] cmd: 0 set value, 1 refresh tick
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [2:0] digit_drive, [10:3] segment_drive, [15:11] zero
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data  // polarity: 1 inverts digit and segment levels
);

   logic                     req_xfer;
   logic                     buf_full;
   logic                     is_tick;
   ssmd_pkg::codes_upd_type  codes_upd;
   ssmd_pkg::pins_type       pins_next;
   ssmd_pkg::pins_type       rsp_pins;

   assign req_tready = !buf_full;
   assign req_xfer   = req_tvalid && req_tready;
   assign is_tick    = req_xfer && (ssmd_pkg::cmd_type'(req_tuser) == ssmd_pkg::CMD_TICK);

   // set-value path: value to blanked digit codes
   ssmd_digit_split u_split (
      .load  (req_xfer && (ssmd_pkg::cmd_type'(req_tuser) == ssmd_pkg::CMD_SET)),
      .value (req_tdata[ssmd_pkg::VALUE_W-1:0]),
      .upd   (codes_upd)
   );

   // display state and scan sequencing
   ssmd_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .tick        (is_tick),
      .upd         (codes_upd),
      .pins_next   (pins_next)
   );

   // result register with skid entry
   ssmd_out_buf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (pins_next),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_pins)
   );

   assign rsp_tdata = {5'b0, rsp_pins.segment, rsp_pins.digit};

endmodule

`default_nettype wire
